// File: design/swm_pkg.sv
package swm_pkg;

    localparam int MAX_WINDOW   = 64;
    localparam int SAMPLE_WIDTH = 16;
    localparam int POS_W        = 8;
    localparam int WIN_W        = 7;
    localparam int FILL_W       = 7;
    localparam int DATA_W       = ((SAMPLE_WIDTH + 7) / 8) * 8;

    localparam logic [WIN_W-1:0]  WIN_RESET = WIN_W'(3);
    localparam logic [FILL_W-1:0] FILL_MAX  = '1;

    typedef logic signed [SAMPLE_WIDTH-1:0] t_sample;
    typedef logic [POS_W-1:0]               t_pos;
    typedef logic [WIN_W-1:0]               t_win;

    // command broadcast to every cell of the row
    typedef struct packed {
        logic    load;   // an item is taken in this cycle
        logic    shift;  // the row moves one place toward the head
        logic    clear;  // the item opens a new sequence
        t_sample sample;
        t_pos    pos;
        t_win    win;
    } t_cell_cmd;

    // what a cell shows its neighbors
    typedef struct packed {
        logic    valid;
        logic    keep;
        t_sample value;
        t_pos    pos;
    } t_link;

endpackage

// File: design/swm_cell.sv
module swm_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  swm_pkg::t_cell_cmd i_cmd,
    input  logic              i_head,
    input  logic              i_left_keep,
    input  swm_pkg::t_link    i_right,
    output swm_pkg::t_link    o_link,
    output logic              o_aged,
    output swm_pkg::t_sample  o_next_value
);
    import swm_pkg::*;

    logic    r_valid;
    t_sample r_value;
    t_pos    r_pos;
    logic    n_valid;
    t_sample n_value;
    t_pos    n_pos;
    logic    keep;
    logic    not_above;
    t_pos    age;

    // candidate survives unless the new item is at least as large
    assign not_above = (r_value <= i_cmd.sample);
    assign keep      = r_valid && !i_cmd.clear && !(i_cmd.load && not_above);
    assign age       = t_pos'(i_cmd.pos - r_pos);
    assign o_aged    = r_valid && (age >= POS_W'(i_cmd.win));

    always_comb begin
        n_valid = keep;
        n_value = r_value;
        n_pos   = r_pos;
        if (i_cmd.shift) begin
            if (i_right.keep) begin
                n_valid = 1'b1;
                n_value = i_right.value;
                n_pos   = i_right.pos;
            end else if (i_cmd.load && (keep || i_head)) begin
                n_valid = 1'b1;
                n_value = i_cmd.sample;
                n_pos   = i_cmd.pos;
            end else begin
                n_valid = 1'b0;
            end
        end else if (i_cmd.load && !keep && i_left_keep) begin
            n_valid = 1'b1;
            n_value = i_cmd.sample;
            n_pos   = i_cmd.pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        r_pos   <= n_pos;
    end

    assign o_link.valid  = r_valid;
    assign o_link.keep   = keep;
    assign o_link.value  = r_value;
    assign o_link.pos    = r_pos;
    assign o_next_value  = n_value;

endmodule

// File: design/sliding_window_maximum.sv
// sliding window maximum over a stream of signed samples
// input channel (s_axis): tdata carries the sample, tuser carries the start
// flag; an item with the start flag set opens a new sequence and drops all
// candidates, the position counter and the fill counter before it is taken
// output channel (m_axis): tdata carries the maximum of the last window_size
// samples; a sequence gives no item until window_size samples have arrived
// config channel (cfg): one write sets window_size; zero acts as one, values
// above the row length act as the row length; write it while the block is idle
//
// the candidate list lives in a row of identical cells, head at cell 0; in
// each cycle every cell compares itself with the new sample and takes its
// content from itself, its right neighbor or the sample
// the result item is registered and shows up in the cycle after its sample is taken
// throughput: one item per cycle while the output is free; after the window is
// made smaller, each stale candidate beyond the first is dropped by moving the
// row while the item waits; cfg is held off
// during that time
// stall: a single output register holds the result; a new item is taken in
// the same cycle the held result leaves, so a stalled receiver stalls input
// reset: empty list, counters at zero, window_size back to 3
module sliding_window_maximum (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // input items
    input  logic                      i_s_axis_tvalid,
    output logic                      o_s_axis_tready,
    input  logic [swm_pkg::DATA_W-1:0] i_s_axis_tdata,  // [15:0] sample
    input  logic                      i_s_axis_tuser,  // [0] start_req
    // result items
    output logic                      o_m_axis_tvalid,
    input  logic                      i_m_axis_tready,
    output logic [swm_pkg::DATA_W-1:0] o_m_axis_tdata,  // [15:0] window_max
    // window_size register
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [swm_pkg::WIN_W-1:0]  i_cfg_data
);
    import swm_pkg::*;

    // control state
    t_win          r_win;
    t_pos          r_pos;
    logic [FILL_W-1:0] r_fill;
    logic          r_out_valid;
    t_sample       r_out_data;

    t_win          win_eff;
    t_sample       sample;
    logic          start;
    logic          cleanup;
    logic          out_free;
    logic          accept;
    logic          emit;
    t_pos          pos_base;
    logic [FILL_W-1:0] fill_base;
    logic [FILL_W-1:0] n_fill;
    t_cell_cmd     cmd;

    // the row and its links; the place beyond the tail is always empty
    t_link         link      [MAX_WINDOW+1];
    logic          aged      [MAX_WINDOW];
    t_sample       next_val  [MAX_WINDOW];

    assign sample = t_sample'(i_s_axis_tdata[SAMPLE_WIDTH-1:0]);
    assign start  = i_s_axis_tuser;

    // clamp the window into 1..MAX_WINDOW
    always_comb begin
        if (r_win == '0) begin
            win_eff = t_win'(1);
        end else if (r_win > t_win'(MAX_WINDOW)) begin
            win_eff = t_win'(MAX_WINDOW);
        end else begin
            win_eff = r_win;
        end
    end

    assign pos_base  = start ? '0 : r_pos;
    assign fill_base = start ? '0 : r_fill;
    assign n_fill    = (fill_base == FILL_MAX) ? FILL_MAX : fill_base + 1'b1;
    assign emit      = (n_fill >= FILL_W'(win_eff));

    // more than one stale candidate at the head: move the row first
    assign cleanup  = i_s_axis_tvalid && !start && aged[1];
    assign out_free = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = out_free && (start || !aged[1]);
    assign accept   = i_s_axis_tvalid && o_s_axis_tready;
    assign o_cfg_ready = !cleanup;

    // a taken item drops at most one head: a stale one or, as a guard, the
    // head of a full row
    always_comb begin
        cmd.load   = accept;
        cmd.clear  = accept && start;
        cmd.sample = sample;
        cmd.pos    = pos_base;
        cmd.win    = win_eff;
        if (accept) begin
            cmd.shift = !start && (aged[0] || link[MAX_WINDOW-1].keep);
        end else begin
            cmd.shift = cleanup;
        end
    end

    assign link[MAX_WINDOW] = '0;

    for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
        swm_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_cmd        (cmd),
            .i_head       ((i == 0) ? 1'b1 : 1'b0),
            .i_left_keep  ((i == 0) ? 1'b1 : link[(i == 0) ? 0 : i-1].keep),
            .i_right      (link[i+1]),
            .o_link       (link[i]),
            .o_aged       (aged[i]),
            .o_next_value (next_val[i])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win       <= WIN_RESET;
            r_pos       <= '0;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_win <= i_cfg_data;
            end
            if (accept) begin
                r_pos       <= t_pos'(pos_base + 1'b1);
                r_fill      <= n_fill;
                r_out_valid <= emit;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // the new head is the window maximum
    always_ff @(posedge i_clk) begin
        if (accept && emit) begin
            r_out_data <= next_val[0];
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = DATA_W'(unsigned'(r_out_data));

endmodule

// File: design/swm_checker.sv
module swm_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_s_axis_tvalid,
    input logic                      o_s_axis_tready,
    input logic                      i_s_axis_tuser,
    input logic                      o_m_axis_tvalid,
    input logic                      i_m_axis_tready,
    input logic [swm_pkg::DATA_W-1:0] o_m_axis_tdata,
    input logic                      o_cfg_ready
);
    import swm_pkg::*;

    // a held result does not change
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("result changed while stalled");

    // every new result comes from an item taken in the previous cycle
    a_out_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> $past(i_s_axis_tvalid && o_s_axis_tready))
        else $error("result without a taken item");

    // config is held off only while a continuing item waits for the row
    a_cfg_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_cfg_ready |-> i_s_axis_tvalid && !i_s_axis_tuser)
        else $error("config stalled without a waiting item");

    // a sequence start is taken at once when the output is empty
    a_start_go: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && i_s_axis_tuser && !o_m_axis_tvalid |-> o_s_axis_tready)
        else $error("start item held back");

    // reset empties the output
    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind sliding_window_maximum swm_checker u_swm_checker (.*);
